@@ hw/rtl/brmm_pkg.sv @@
// Package for the block RMS and mean meter.
// Holds field widths, reset values, opcodes, state codes and the control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brmm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 33;
  localparam int SQSUM_W  = 48;
  localparam int LEN_W    = 17;
  localparam int RECIP_W  = 33;
  localparam int MEAN_W   = 33;
  localparam int RMS_W    = 32;
  localparam int AC_W     = 33;
  localparam int CFG_W    = 33;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_A_W  = 48;
  localparam int MUL_B_W  = 33;
  localparam int MUL_P_W  = 81;
  localparam int SQ_IN_W  = 64;

  localparam logic [LEN_W-1:0]   BLOCK_LENGTH_RST = 17'd65536;
  localparam logic [RECIP_W-1:0] RECIP_RST        = 33'd65536;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_LENGTH   = 2'd0,
    CFG_LENGTH_RECIP   = 2'd1,
    CFG_SIGNED_SAMPLES = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_MEAN   = 2'd0,
    MUL_MEANSQ = 2'd1,
    MUL_MEAN2  = 2'd2
  } mul_sel_t;

  typedef enum logic {
    SQ_RMS = 1'b0,
    SQ_AC  = 1'b1
  } sqrt_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MSQ_GO,
    S_MSQ_WAIT,
    S_MEAN2_GO,
    S_MEAN2_WAIT,
    S_DIFF,
    S_RMS_GO,
    S_RMS_WAIT,
    S_AC_GO,
    S_AC_WAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      accept;
    logic      mul_start;
    mul_sel_t  mul_sel;
    logic      mean_load;
    logic      meansq_load;
    logic      mean2_load;
    logic      diff_load;
    logic      sqrt_start;
    sqrt_sel_t sqrt_sel;
    logic      rms_load;
    logic      ac_load;
  } brmm_cmd_t;

  typedef struct packed {
    logic block_end;
    logic mul_done;
    logic sqrt_done;
  } brmm_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/brmm_in_if.sv @@
// Input channel of the meter: valid/ready handshake with opcode and sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface brmm_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/brmm_out_if.sv @@
// Result channel of the meter: valid/ready handshake with the held results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface brmm_out_if;
  logic               valid;
  logic               ready;
  logic               block_done;
  logic signed [32:0] mean_value;
  logic        [31:0] rms_value;
  logic signed [32:0] ac_rms_value;

  modport source (output valid, output block_done, output mean_value, output rms_value,
                  output ac_rms_value, input ready);
  modport sink   (input valid, input block_done, input mean_value, input rms_value,
                  input ac_rms_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/brmm_mul.sv @@
// Sequential 48x33 multiplier built from one 16x33 multiplier: three partial
// products, each registered and then accumulated. Depends on brmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brmm_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [brmm_pkg::MUL_A_W-1:0] a,
  input  wire logic [brmm_pkg::MUL_B_W-1:0] b,
  output logic      [brmm_pkg::MUL_P_W-1:0] p,
  output logic                              done
);
  import brmm_pkg::*;

  localparam int PROD_W = 16 + MUL_B_W;

  logic [1:0]          k_r;
  logic                busy_r;
  logic                done_r;
  logic [MUL_A_W-1:0]  a_r;
  logic [MUL_B_W-1:0]  b_r;
  logic [PROD_W-1:0]   prod_r;
  logic [MUL_P_W-1:0]  acc_r;
  logic [15:0]         chunk;
  logic [MUL_P_W-1:0]  addend;

  // Pick the 16-bit slice of the first operand for this beat.
  always_comb begin
    case (k_r)
      2'd0:    chunk = a_r[15:0];
      2'd1:    chunk = a_r[31:16];
      default: chunk = a_r[47:32];
    endcase
  end

  // Align the previous partial product to its weight.
  always_comb begin
    case (k_r)
      2'd1:    addend = MUL_P_W'(prod_r);
      2'd2:    addend = MUL_P_W'(prod_r) << 16;
      default: addend = MUL_P_W'(prod_r) << 32;
    endcase
  end

  // Beat counter and handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= 2'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (k_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 2'd0;
      end else if (busy_r) begin
        k_r <= k_r + 2'd1;
        if (k_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Partial product register, then accumulate the registered product.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      if (k_r != 2'd3) begin
        prod_r <= PROD_W'(chunk) * PROD_W'(b_r);
      end
      if (k_r != 2'd0) begin
        acc_r <= acc_r + addend;
      end
    end
  end

  assign p    = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/brmm_sqrt.sv @@
// Integer square root of a 64-bit value, one result bit per cycle for a 32-bit root.
// Depends on brmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brmm_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [brmm_pkg::SQ_IN_W-1:0] x,
  output logic      [31:0]                  root,
  output logic                              done
);
  import brmm_pkg::*;

  logic [SQ_IN_W-1:0] x_r;
  logic [SQ_IN_W-1:0] r_r;
  logic [SQ_IN_W-1:0] bit_r;
  logic [4:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [SQ_IN_W-1:0] trial;
  logic               fits;

  // Trial subtrahend for the current bit pair.
  assign trial = r_r + bit_r;
  assign fits  = (x_r >= trial);

  // Step counter and handshake.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 5'd0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd31);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Restoring square root step.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= {2'b01, {(SQ_IN_W-2){1'b0}}};
    end else if (busy_r) begin
      if (fits) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = r_r[31:0];
  assign done = done_r;

endmodule

`default_nettype wire

@@ hw/rtl/brmm_dp.sv @@
// Datapath of the meter: configuration, accumulators, block-end arithmetic and held results.
// Depends on brmm_pkg, brmm_mul and brmm_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module brmm_dp #(
  parameter int MAX_BLOCK_LENGTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [brmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brmm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_opcode,
  input  wire logic [brmm_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire brmm_pkg::brmm_cmd_t            cmd,
  output brmm_pkg::brmm_stat_t                stat,
  output logic                                out_block_done,
  output logic [brmm_pkg::MEAN_W-1:0]         out_mean,
  output logic [brmm_pkg::RMS_W-1:0]          out_rms,
  output logic [brmm_pkg::AC_W-1:0]           out_ac_rms
);
  import brmm_pkg::*;

  localparam int CW   = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int CMPW = ((CW > LEN_W) ? CW : LEN_W) + 1;

  // Configuration registers.
  logic [LEN_W-1:0]   block_length_r;
  logic [RECIP_W-1:0] recip_r;
  logic               signed_r;

  // Accumulators and block snapshot.
  logic [CW-1:0]      count_r;
  logic [SUM_W-1:0]   sum_r;
  logic [SQSUM_W-1:0] sqsum_r;
  logic [SUM_W-1:0]   sum_blk_r;
  logic [SQSUM_W-1:0] sqsum_blk_r;
  logic               done_r;

  // Block-end intermediates.
  logic [MEAN_W-1:0]  q16_r;
  logic [63:0]        meansq_r;
  logic [63:0]        mean2_r;
  logic [63:0]        diff_r;
  logic               diff_neg_r;

  // Held results.
  logic [MEAN_W-1:0]  held_mean_r;
  logic [RMS_W-1:0]   held_rms_r;
  logic [AC_W-1:0]    held_ac_r;

  logic                sneg;
  logic [SUM_W-1:0]    s_ext;
  logic [SAMPLE_W-1:0] mag;
  logic [31:0]         sq;
  logic [SUM_W-1:0]    sum_add;
  logic [SQSUM_W-1:0]  sqsum_add;
  logic [CMPW-1:0]     cnt_inc;
  logic [CMPW-1:0]     bl_ext;
  logic [CMPW-1:0]     max_ext;
  logic [CMPW-1:0]     len_eff;
  logic                block_end;

  logic                blk_neg;
  logic [SUM_W-1:0]    blk_mag;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                mul_done;
  logic [49:0]         q_full;
  logic [MEAN_W-1:0]   q16_c;
  logic [63:0]         p_sat;
  logic [SQ_IN_W-1:0]  sq_in;
  logic [31:0]         root;
  logic                sqrt_done;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_length_r <= BLOCK_LENGTH_RST;
      recip_r        <= RECIP_RST;
      signed_r       <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_LENGTH:   block_length_r <= cfg_data[LEN_W-1:0];
        CFG_LENGTH_RECIP:   recip_r        <= cfg_data[RECIP_W-1:0];
        CFG_SIGNED_SAMPLES: signed_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sample interpretation, square and running sums.
  assign sneg      = signed_r && in_sample[SAMPLE_W-1];
  assign s_ext     = sneg ? {{(SUM_W-SAMPLE_W){1'b1}}, in_sample}
                          : {{(SUM_W-SAMPLE_W){1'b0}}, in_sample};
  assign mag       = sneg ? SAMPLE_W'(17'h10000 - {1'b0, in_sample}) : in_sample;
  assign sq        = 32'(mag) * 32'(mag);
  assign sum_add   = sum_r + s_ext;
  assign sqsum_add = sqsum_r + SQSUM_W'(sq);

  // Effective block length and end-of-block test.
  assign cnt_inc   = CMPW'(count_r) + CMPW'(1);
  assign bl_ext    = CMPW'(block_length_r);
  assign max_ext   = CMPW'(MAX_BLOCK_LENGTH);
  assign len_eff   = (block_length_r == '0) ? CMPW'(1)
                   : ((bl_ext > max_ext) ? max_ext : bl_ext);
  assign block_end = (in_opcode == OP_ADD) && (cnt_inc >= len_eff);

  // Accumulators, count and the snapshot taken when a block completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
      done_r  <= 1'b0;
    end else if (cmd.accept) begin
      if (in_opcode == OP_CLEAR) begin
        count_r <= '0;
        sum_r   <= '0;
        sqsum_r <= '0;
        done_r  <= 1'b0;
      end else if (block_end) begin
        count_r <= '0;
        sum_r   <= '0;
        sqsum_r <= '0;
        done_r  <= 1'b1;
      end else begin
        count_r <= cnt_inc[CW-1:0];
        sum_r   <= sum_add;
        sqsum_r <= sqsum_add;
        done_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && block_end) begin
      sum_blk_r   <= sum_add;
      sqsum_blk_r <= sqsum_add;
    end
  end

  // Shared multiplier operand selection.
  assign blk_neg = sum_blk_r[SUM_W-1];
  assign blk_mag = blk_neg ? (SUM_W'(0) - sum_blk_r) : sum_blk_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_MEAN: begin
        mul_a = MUL_A_W'(blk_mag);
        mul_b = recip_r;
      end
      MUL_MEANSQ: begin
        mul_a = sqsum_blk_r;
        mul_b = recip_r;
      end
      default: begin
        mul_a = MUL_A_W'(q16_r);
        mul_b = q16_r;
      end
    endcase
  end

  brmm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .done  (mul_done)
  );

  // Mean magnitude in Q.16, clamped to what the signed result can carry.
  assign q_full = mul_p[65:16];
  always_comb begin
    if (blk_neg) begin
      q16_c = (q_full > 50'h1_0000_0000) ? 33'h1_0000_0000 : q_full[32:0];
    end else begin
      q16_c = (q_full > 50'h0_FFFF_FFFF) ? 33'h0_FFFF_FFFF : q_full[32:0];
    end
  end

  // Products above 64 bits saturate.
  assign p_sat = (mul_p[MUL_P_W-1:64] != '0) ? {64{1'b1}} : mul_p[63:0];

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      q16_r <= q16_c;
    end
    if (cmd.meansq_load) begin
      meansq_r <= p_sat;
    end
    if (cmd.mean2_load) begin
      mean2_r <= p_sat;
    end
    if (cmd.diff_load) begin
      if (meansq_r >= mean2_r) begin
        diff_r     <= meansq_r - mean2_r;
        diff_neg_r <= 1'b0;
      end else begin
        diff_r     <= mean2_r - meansq_r;
        diff_neg_r <= 1'b1;
      end
    end
  end

  // Square root of the mean square, then of the variance magnitude.
  assign sq_in = (cmd.sqrt_sel == SQ_RMS) ? meansq_r : diff_r;

  brmm_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .x     (sq_in),
    .root  (root),
    .done  (sqrt_done)
  );

  // Held results, cleared by reset and by the clear opcode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_mean_r <= '0;
      held_rms_r  <= '0;
      held_ac_r   <= '0;
    end else if (cmd.accept && (in_opcode == OP_CLEAR)) begin
      held_mean_r <= '0;
      held_rms_r  <= '0;
      held_ac_r   <= '0;
    end else begin
      if (cmd.mean_load) begin
        held_mean_r <= blk_neg ? (MEAN_W'(0) - q16_c) : q16_c;
      end
      if (cmd.rms_load) begin
        held_rms_r <= root;
      end
      if (cmd.ac_load) begin
        held_ac_r <= diff_neg_r ? (AC_W'(0) - {1'b0, root}) : {1'b0, root};
      end
    end
  end

  assign stat.block_end = block_end;
  assign stat.mul_done  = mul_done;
  assign stat.sqrt_done = sqrt_done;

  assign out_block_done = done_r;
  assign out_mean       = held_mean_r;
  assign out_rms        = held_rms_r;
  assign out_ac_rms     = held_ac_r;

endmodule

`default_nettype wire

@@ hw/rtl/brmm_ctrl.sv @@
// Controller of the meter: handshakes and the block-end arithmetic sequence.
// Depends on brmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brmm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire brmm_pkg::brmm_stat_t stat,
  output brmm_pkg::brmm_cmd_t       cmd
);
  import brmm_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_load;

  // Take a beat only when idle and the result slot is free or draining.
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:       if (accept && stat.block_end) state_nxt = S_MEAN_GO;
      S_MEAN_GO:    state_nxt = S_MEAN_WAIT;
      S_MEAN_WAIT:  if (stat.mul_done) state_nxt = S_MSQ_GO;
      S_MSQ_GO:     state_nxt = S_MSQ_WAIT;
      S_MSQ_WAIT:   if (stat.mul_done) state_nxt = S_MEAN2_GO;
      S_MEAN2_GO:   state_nxt = S_MEAN2_WAIT;
      S_MEAN2_WAIT: if (stat.mul_done) state_nxt = S_DIFF;
      S_DIFF:       state_nxt = S_RMS_GO;
      S_RMS_GO:     state_nxt = S_RMS_WAIT;
      S_RMS_WAIT:   if (stat.sqrt_done) state_nxt = S_AC_GO;
      S_AC_GO:      state_nxt = S_AC_WAIT;
      S_AC_WAIT:    if (stat.sqrt_done) state_nxt = S_FINISH;
      S_FINISH:     state_nxt = S_IDLE;
      default:      state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.mul_sel  = MUL_MEAN;
    cmd.sqrt_sel = SQ_RMS;
    out_load     = 1'b0;
    unique case (state_r)
      S_IDLE:       out_load = accept && !stat.block_end;
      S_MEAN_GO:    cmd.mul_start = 1'b1;
      S_MEAN_WAIT:  cmd.mean_load = stat.mul_done;
      S_MSQ_GO: begin
        cmd.mul_sel   = MUL_MEANSQ;
        cmd.mul_start = 1'b1;
      end
      S_MSQ_WAIT:   cmd.meansq_load = stat.mul_done;
      S_MEAN2_GO: begin
        cmd.mul_sel   = MUL_MEAN2;
        cmd.mul_start = 1'b1;
      end
      S_MEAN2_WAIT: cmd.mean2_load = stat.mul_done;
      S_DIFF:       cmd.diff_load = 1'b1;
      S_RMS_GO:     cmd.sqrt_start = 1'b1;
      S_RMS_WAIT:   cmd.rms_load = stat.sqrt_done;
      S_AC_GO: begin
        cmd.sqrt_sel   = SQ_AC;
        cmd.sqrt_start = 1'b1;
      end
      S_AC_WAIT: begin
        cmd.sqrt_sel = SQ_AC;
        cmd.ac_load  = stat.sqrt_done;
      end
      S_FINISH:     out_load = 1'b1;
      default: ;
    endcase
  end

  // Result slot.
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A beat that does not end a block yields its result on the next cycle.
  a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !stat.block_end) |=> out_valid_r)
    else $error("result missing after a non block-end beat");

  // A block-end beat leaves the result slot empty while the arithmetic runs.
  a_block_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stat.block_end) |=> (!out_valid_r && state_r == S_MEAN_GO))
    else $error("block-end beat did not start the arithmetic");

  // A result appears only after an accepted beat or at the end of the sequence.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(accept) || $past(state_r) == S_FINISH))
    else $error("result raised without a cause");

  // Nothing is accepted while the arithmetic is in flight.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("beat accepted during block-end arithmetic");

endmodule

`default_nettype wire

@@ hw/rtl/block_rms_mean_meter_top.sv @@
// Block RMS and mean meter.
//
// Input channel in_ch carries an opcode and a 16-bit sample; opcode add folds
// the sample into the running sum and sum of squares, opcode clear zeroes the
// accumulators and the held results. Each input beat gives exactly one result
// beat on out_ch with block_done and the held mean, rms and ac rms values.
// Configuration (block length, Q1.32 reciprocal, sample signedness) is written
// through cfg_we, cfg_index and cfg_data while the meter is idle.
//
// A beat that does not complete a block returns its result in the cycle after
// acceptance, so such beats stream at one per cycle while out_ch is taken.
// A beat that completes a block returns its result once the block-end sequence
// is done: three multiplies on one shared 16x33 multiplier, a subtract step,
// two square roots and a finishing step. The input is held off meanwhile.
// The result register decouples the two sides: a new beat is taken in the same
// cycle the previous result is taken. When the receiver stalls, the result is
// held and the input is held off. Synchronous reset restores the default
// configuration and zeroes counts, sums and held results.
// Depends on brmm_pkg, brmm_in_if, brmm_out_if, brmm_ctrl and brmm_dp.
`timescale 1ns / 1ps
`default_nettype none

module block_rms_mean_meter_top #(
  parameter int MAX_BLOCK_LENGTH = 65536
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [brmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [brmm_pkg::CFG_W-1:0]     cfg_data,
  brmm_in_if.sink                             in_ch,
  brmm_out_if.source                          out_ch
);
  import brmm_pkg::*;

  brmm_cmd_t  cmd;
  brmm_stat_t stat;
  logic [MEAN_W-1:0] mean_w;
  logic [AC_W-1:0]   ac_w;

  // Sequencing and handshakes.
  brmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Accumulation and block-end arithmetic.
  brmm_dp #(
    .MAX_BLOCK_LENGTH (MAX_BLOCK_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_opcode      (in_ch.opcode),
    .in_sample      (in_ch.sample),
    .cmd            (cmd),
    .stat           (stat),
    .out_block_done (out_ch.block_done),
    .out_mean       (mean_w),
    .out_rms        (out_ch.rms_value),
    .out_ac_rms     (ac_w)
  );

  assign out_ch.mean_value   = $signed(mean_w);
  assign out_ch.ac_rms_value = $signed(ac_w);

endmodule

`default_nettype wire
